### src/uue_pkg.sv
// Shared types, constants and the 6-bit character map for the uuencode stream encoder.
// No dependencies; every module of the block imports this package.
package uue_pkg;

    localparam int LINE_BYTES_DEF = 45;

    localparam logic [7:0] CHAR_NL = 8'h0A;
    localparam logic [7:0] CHAR_BQ = 8'h60;
    localparam logic [7:0] CHAR_SP = 8'h20;
    localparam logic [7:0] CHAR_OFS = 8'h20;

    // configuration register indexes
    localparam logic CFG_OMIT_NL = 1'b0;
    localparam logic CFG_ZERO_BQ = 1'b1;

    // read offsets inside a three-byte group
    localparam logic [1:0] RD_OFF_A = 2'd0;
    localparam logic [1:0] RD_OFF_B = 2'd1;
    localparam logic [1:0] RD_OFF_C = 2'd2;

    localparam logic [7:0] GROUP_BYTES = 8'd3;

    typedef enum logic [2:0] {
        SEL_LEN,
        SEL_G0,
        SEL_G1,
        SEL_G2,
        SEL_G3,
        SEL_NL,
        SEL_ZERO
    } t_char_sel;

    typedef struct packed {
        logic       rd_en;
        logic [1:0] rd_off;
        logic       cap_a;
        logic       cap_b;
        logic       cap_c;
        logic       clr_pos;
        logic       adv_pos;
        logic       load_out;
        t_char_sel  char_sel;
        logic       out_last;
        logic       out_done;
    } t_dp_cmd;

    typedef struct packed {
        logic emit;
        logic groups_done;
        logic out_free;
        logic omit_nl;
    } t_dp_stat;

    function automatic logic [7:0] enc6(input logic [5:0] v, input logic zero_bq);
        logic [7:0] ch;
        begin
            if (v == 6'd0) begin
                ch = zero_bq ? CHAR_BQ : CHAR_SP;
            end else begin
                ch = {2'b00, v} + CHAR_OFS;
            end
            return ch;
        end
    endfunction

endpackage

### src/uue_ctrl.sv
// Sequencer of the uuencode stream encoder: walks a line through length, group fetch,
// group characters, newline and terminating line. Depends on uue_pkg.
module uue_ctrl
    import uue_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_acc,
    input  logic     i_final_byte,
    input  t_dp_stat i_stat,
    output logic     o_busy,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LEN,
        S_F0,
        S_F1,
        S_F2,
        S_C0,
        S_C1,
        S_C2,
        S_C3,
        S_NL,
        S_TERM,
        S_TNL
    } t_state;

    t_state r_state, n_state;
    logic   r_fin, n_fin;

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_fin   = r_fin;
        o_cmd   = '0;
        o_cmd.char_sel = SEL_LEN;
        case (r_state)
            S_IDLE: begin
                if (i_acc) begin
                    n_fin = i_final_byte;
                    if (i_stat.emit) begin
                        n_state = S_LEN;
                    end
                end
            end
            S_LEN: begin
                o_cmd.char_sel = SEL_LEN;
                o_cmd.clr_pos  = 1'b1;
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_F0;
                end else begin
                    o_cmd.clr_pos = 1'b0;
                end
            end
            S_F0: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_off = RD_OFF_A;
                n_state = S_F1;
            end
            S_F1: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_off = RD_OFF_B;
                o_cmd.cap_a  = 1'b1;
                n_state = S_F2;
            end
            S_F2: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_off = RD_OFF_C;
                o_cmd.cap_b  = 1'b1;
                n_state = S_C0;
            end
            S_C0: begin
                // read data holds until the next fetch, so capture while waiting
                o_cmd.cap_c    = 1'b1;
                o_cmd.char_sel = SEL_G0;
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_C1;
                end
            end
            S_C1: begin
                o_cmd.char_sel = SEL_G1;
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_C2;
                end
            end
            S_C2: begin
                o_cmd.char_sel = SEL_G2;
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_C3;
                end
            end
            S_C3: begin
                o_cmd.char_sel = SEL_G3;
                if (i_stat.groups_done && i_stat.omit_nl && !r_fin) begin
                    o_cmd.out_last = 1'b1;
                end
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.adv_pos  = 1'b1;
                    if (!i_stat.groups_done) begin
                        n_state = S_F0;
                    end else if (!i_stat.omit_nl) begin
                        n_state = S_NL;
                    end else if (r_fin) begin
                        n_state = S_TERM;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_NL: begin
                o_cmd.char_sel = SEL_NL;
                o_cmd.out_last = !r_fin;
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = r_fin ? S_TERM : S_IDLE;
                end
            end
            S_TERM: begin
                o_cmd.char_sel = SEL_ZERO;
                o_cmd.out_last = i_stat.omit_nl;
                o_cmd.out_done = i_stat.omit_nl;
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = i_stat.omit_nl ? S_IDLE : S_TNL;
                end
            end
            S_TNL: begin
                o_cmd.char_sel = SEL_NL;
                o_cmd.out_last = 1'b1;
                o_cmd.out_done = 1'b1;
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fin   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fin   <= n_fin;
        end
    end

endmodule

### src/uue_dpath.sv
// Datapath of the uuencode stream encoder: line store, fill and group counters,
// group byte registers, configuration registers and the output register. Depends on uue_pkg.
module uue_dpath
    import uue_pkg::*;
#(
    parameter int LINE_BYTES = LINE_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic       i_cfg_data,
    input  logic       i_acc,
    input  logic [7:0] i_data_byte,
    input  logic       i_final_byte,
    input  t_dp_cmd    i_cmd,
    input  logic       i_out_stall,
    output t_dp_stat   o_stat,
    output logic       o_out_valid,
    output logic [7:0] o_out_char,
    output logic       o_out_last,
    output logic       o_message_done
);

    localparam int FW = $clog2(LINE_BYTES + 1);
    localparam int AW = $clog2(LINE_BYTES);

    logic [7:0]  mem [LINE_BYTES];
    logic [7:0]  r_rd_data;
    logic        r_rd_zero;

    logic [FW-1:0] r_fill, n_fill;
    logic [FW-1:0] r_len;
    logic [FW-1:0] r_pos;
    logic [7:0]    r_a, r_b, r_c;
    logic          r_omit_nl, r_zero_bq;

    logic          r_out_valid;
    logic [7:0]    r_out_char;
    logic          r_out_last, r_out_done;

    logic [FW:0]   rd_idx;
    logic          rd_hit;
    logic          emit;
    logic [7:0]    rd_byte;
    logic [7:0]    sel_char;

    assign n_fill = r_fill + FW'(1);
    assign emit   = (n_fill == FW'(LINE_BYTES)) || i_final_byte;
    assign rd_idx = {1'b0, r_pos} + (FW + 1)'(i_cmd.rd_off);
    assign rd_hit = rd_idx < {1'b0, r_len};
    // bytes past the line end read as zero padding
    assign rd_byte = r_rd_zero ? 8'd0 : r_rd_data;

    assign o_stat.emit        = emit;
    assign o_stat.groups_done = ({1'b0, r_pos} + (FW + 1)'(GROUP_BYTES)) >= {1'b0, r_len};
    assign o_stat.out_free    = !r_out_valid || !i_out_stall;
    assign o_stat.omit_nl     = r_omit_nl;

    always_comb begin
        case (i_cmd.char_sel)
            SEL_LEN:  sel_char = enc6(6'(r_len), r_zero_bq);
            SEL_G0:   sel_char = enc6(r_a[7:2], r_zero_bq);
            SEL_G1:   sel_char = enc6({r_a[1:0], r_b[7:4]}, r_zero_bq);
            SEL_G2:   sel_char = enc6({r_b[3:0], r_c[7:6]}, r_zero_bq);
            SEL_G3:   sel_char = enc6(r_c[5:0], r_zero_bq);
            SEL_NL:   sel_char = CHAR_NL;
            SEL_ZERO: sel_char = enc6(6'd0, r_zero_bq);
            default:  sel_char = CHAR_NL;
        endcase
    end

    // line store: one write port for input bytes, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            mem[r_fill[AW-1:0]] <= i_data_byte;
        end
        if (i_cmd.rd_en && rd_hit) begin
            r_rd_data <= mem[rd_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_rd_zero   <= 1'b0;
            r_omit_nl   <= 1'b0;
            r_zero_bq   <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_OMIT_NL: r_omit_nl <= i_cfg_data;
                    CFG_ZERO_BQ: r_zero_bq <= i_cfg_data;
                    default:     r_omit_nl <= r_omit_nl;
                endcase
            end
            if (i_acc) begin
                r_fill <= emit ? '0 : n_fill;
            end
            if (i_cmd.rd_en) begin
                r_rd_zero <= !rd_hit;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc && emit) begin
            r_len <= n_fill;
        end
        if (i_cmd.clr_pos) begin
            r_pos <= '0;
        end else if (i_cmd.adv_pos) begin
            r_pos <= r_pos + FW'(GROUP_BYTES);
        end
        if (i_cmd.cap_a) begin
            r_a <= rd_byte;
        end
        if (i_cmd.cap_b) begin
            r_b <= rd_byte;
        end
        if (i_cmd.cap_c) begin
            r_c <= rd_byte;
        end
        if (i_cmd.load_out) begin
            r_out_char <= sel_char;
            r_out_last <= i_cmd.out_last;
            r_out_done <= i_cmd.out_done;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_char     = r_out_char;
    assign o_out_last     = r_out_last;
    assign o_message_done = r_out_done;

endmodule

### src/uuencode_stream_encoder_unit.sv
// Top level of the uuencode stream encoder: sequencer plus datapath.
// Depends on uue_pkg, uue_ctrl and uue_dpath.
//
// Bytes are taken one per cycle while a line is being gathered; a byte that neither fills
// the line nor carries the final flag produces nothing. When the line fills (LINE_BYTES
// bytes) or the final byte arrives, input is stalled while the line is sent: the length
// character, then for each three-byte group three reads through the single read port of
// the line store and four characters through the one-character output register, then the
// newline unless it is omitted, and the terminating line at message end. Sending also waits
// while the output register is held by a stall on the output side. Input is taken again as
// soon as the last character is loaded, while it still waits to be transferred.
module uuencode_stream_encoder_unit
    import uue_pkg::*;
#(
    parameter int LINE_BYTES = LINE_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic       i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_final_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_char,
    output logic       o_out_last,
    output logic       o_message_done
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     busy;
    logic     acc;

    assign o_in_stall = busy;
    assign acc        = i_in_valid && !busy;

    uue_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_acc        (acc),
        .i_final_byte (i_final_byte),
        .i_stat       (stat),
        .o_busy       (busy),
        .o_cmd        (cmd)
    );

    uue_dpath #(
        .LINE_BYTES (LINE_BYTES)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_acc          (acc),
        .i_data_byte    (i_data_byte),
        .i_final_byte   (i_final_byte),
        .i_cmd          (cmd),
        .i_out_stall    (i_out_stall),
        .o_stat         (stat),
        .o_out_valid    (o_out_valid),
        .o_out_char     (o_out_char),
        .o_out_last     (o_out_last),
        .o_message_done (o_message_done)
    );

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_message_done) |-> o_out_last)
        else $error("message_done without out_last");

    a_final_starts_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_final_byte) |=> o_in_stall)
        else $error("final byte did not start line output");

    a_partial_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !stat.emit) |=> !o_in_stall)
        else $error("partial line stalled input");

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> stat.out_free)
        else $error("output register overwritten while stalled");

endmodule

### tb/testbench.sv
// Self-checking bench for uuencode_stream_encoder_unit: random messages, random stalls.
// Depends on uue_pkg and the encoder RTL; a line predictor scores every output character.
module testbench
    import uue_pkg::*;
();

    localparam int LINE_LEN = LINE_BYTES_DEF;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        bit [7:0] ch;
        bit       last;
        bit       done;
    } t_uu_char;

    class t_uu_line_predictor;
        bit [7:0] line_bytes [64];
        int       fill;
        bit       omit_nl;
        bit       zero_bq;
        t_uu_char expected_chars [$];
        int       mismatches;

        function new();
            fill = 0;
            omit_nl = 1'b0;
            zero_bq = 1'b1;
            mismatches = 0;
        endfunction

        function void set_reg(bit idx, bit val);
            if (idx == CFG_OMIT_NL) begin
                omit_nl = val;
            end else begin
                zero_bq = val;
            end
        endfunction

        function bit [7:0] map6(bit [5:0] v);
            if (v == 6'd0) begin
                return zero_bq ? CHAR_BQ : CHAR_SP;
            end
            return {2'b00, v} + 8'h20;
        endfunction

        // Note one accepted byte and queue every character it releases.
        function void take_byte(bit [7:0] b, bit fin);
            bit [7:0] run [$];
            int       n;
            int       len;
            bit [7:0] a;
            bit [7:0] bb;
            bit [7:0] c;
            t_uu_char item;
            if (fill >= LINE_LEN) begin
                fill = 0;
            end
            line_bytes[fill] = b;
            fill++;
            if (fill >= LINE_LEN || fin) begin
                len = fill;
                run.push_back(map6(len[5:0]));
                for (int i = 0; i < len; i += 3) begin
                    a = line_bytes[i];
                    bb = (i + 1 < len) ? line_bytes[i + 1] : 8'h00;
                    c = (i + 2 < len) ? line_bytes[i + 2] : 8'h00;
                    run.push_back(map6(a[7:2]));
                    run.push_back(map6({a[1:0], bb[7:4]}));
                    run.push_back(map6({bb[3:0], c[7:6]}));
                    run.push_back(map6(c[5:0]));
                end
                if (!omit_nl) begin
                    run.push_back(CHAR_NL);
                end
                fill = 0;
            end
            if (fin) begin
                run.push_back(map6(6'd0));
                if (!omit_nl) begin
                    run.push_back(CHAR_NL);
                end
            end
            n = run.size();
            for (int i = 0; i < n; i++) begin
                item.ch = run[i];
                item.last = (i == n - 1);
                item.done = fin && (i == n - 1);
                expected_chars.push_back(item);
            end
        endfunction

        function void check_char(bit [7:0] ch, bit last, bit done);
            t_uu_char exp_item;
            if (expected_chars.size() == 0) begin
                if (mismatches < MAX_REPORTS) begin
                    $display("unexpected char %02h last %0b done %0b", ch, last, done);
                end
                mismatches++;
                return;
            end
            exp_item = expected_chars.pop_front();
            if (exp_item.ch != ch || exp_item.last != last || exp_item.done != done) begin
                if (mismatches < MAX_REPORTS) begin
                    $display("char mismatch: expected %02h last %0b done %0b,",
                             exp_item.ch, exp_item.last, exp_item.done,
                             " got %02h last %0b done %0b", ch, last, done);
                end
                mismatches++;
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic       cfg_index = 1'b0;
    logic       cfg_data = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] data_byte = 8'h00;
    logic       final_byte = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_char;
    logic       out_last;
    logic       message_done;

    t_uu_line_predictor predictor;
    bit  no_idle = 1'b0;
    bit  hold_out_req = 1'b0;
    int  idle_cycles = 0;

    uuencode_stream_encoder_unit #(
        .LINE_BYTES(LINE_LEN)
    ) DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_data_byte   (data_byte),
        .i_final_byte  (final_byte),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_char    (out_char),
        .o_out_last    (out_last),
        .o_message_done(message_done)
    );

    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (no_idle || r < 12) begin
            return 0;
        end
        if (r < 18) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(15, 50);
    endfunction

    // Drive one byte and hold it until the transfer; returns at the following falling edge.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        final_byte <= fin;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predictor.take_byte(b, fin);
        @(negedge clk);
    endtask

    task automatic send_message(input int len);
        for (int k = 0; k < len; k++) begin
            send_byte(8'($urandom_range(0, 255)), k == len - 1);
        end
    endtask

    task automatic send_random_messages(input int target);
        int sent;
        int len;
        sent = 0;
        while (sent < target) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
            send_message(len);
            sent += len;
        end
    endtask

    // Drop valid, then wait for every queued character plus a little slack.
    task automatic drain();
        in_valid <= 1'b0;
        while (predictor.expected_chars.size() != 0) @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    task automatic write_regs(input logic omit, input logic zbq);
        cfg_we <= 1'b1;
        cfg_index <= CFG_OMIT_NL;
        cfg_data <= omit;
        @(negedge clk);
        predictor.set_reg(CFG_OMIT_NL, omit);
        cfg_index <= CFG_ZERO_BQ;
        cfg_data <= zbq;
        @(negedge clk);
        predictor.set_reg(CFG_ZERO_BQ, zbq);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Output side: random stall bursts, one long hold on request.
    initial begin : out_side
        int stall_left;
        int r;
        bit hold_done;
        stall_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_out_req && !hold_done) begin
                hold_done = 1'b1;
                stall_left = 300;
            end
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                r = $urandom_range(0, 15);
                if (no_idle || r < 10) begin
                    out_stall <= 1'b0;
                end else begin
                    out_stall <= 1'b1;
                    stall_left = (r < 15) ? $urandom_range(0, 2) : $urandom_range(20, 60);
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            predictor.check_char(out_char, out_last, message_done);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        predictor = new();
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_regs(1'b0, 1'b1);
        // Directed: single-byte extremes, short groups, a full group.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'h3C, 1'b1);
        drain();

        // Full line ending on the final byte.
        write_regs(1'b0, 1'b0);
        send_message(LINE_LEN);
        drain();

        write_regs(1'b1, 1'b1);
        no_idle = 1'b1;
        send_random_messages(6);
        no_idle = 1'b0;
        drain();

        // Line wraps inside the message while the output side holds off,
        // so the remaining bytes wait at a stalled input.
        write_regs(1'b1, 1'b0);
        hold_out_req = 1'b1;
        no_idle = 1'b1;
        send_message($urandom_range(LINE_LEN + 1, LINE_LEN + 5));
        no_idle = 1'b0;
        drain();

        write_regs(1'b0, 1'b1);
        send_random_messages(6);
        drain();

        if (predictor.mismatches == 0 && predictor.expected_chars.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

### filelist.f
src/uue_pkg.sv
src/uue_ctrl.sv
src/uue_dpath.sv
src/uuencode_stream_encoder_unit.sv
tb/testbench.sv
